/* sv/tll_pkg.sv */
// Package for the task linked list manager: pool size, index and count widths,
// opcode and status codes. Has no dependencies; every other file imports it.
package tll_pkg;

  localparam int TASK_SLOTS = 32;
  localparam int IDX_W      = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_PUSH_BACK     = 2'd0,
    OP_INSERT_BEFORE = 2'd1,
    OP_POP_FRONT     = 2'd2,
    OP_REMOVE        = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_LINKED = 2'd2,
    ST_ALREADY    = 2'd3
  } status_t;

endpackage

/* sv/tll_in_if.sv */
// Request channel for the task linked list manager: valid/ready plus one opcode beat.
// Depends on tll_pkg.
interface tll_in_if
  import tll_pkg::*;
;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  idx_t    task_index;
  idx_t    anchor_index;
  logic    anchor_valid;

  modport source (output valid, opcode, task_index, anchor_index, anchor_valid,
                  input ready);
  modport sink   (input valid, opcode, task_index, anchor_index, anchor_valid,
                  output ready);
endinterface

/* sv/tll_out_if.sv */
// Result channel for the task linked list manager: valid/ready plus status and list view.
// Depends on tll_pkg.
interface tll_out_if
  import tll_pkg::*;
;
  logic    valid;
  logic    ready;
  status_t status;
  idx_t    popped_index;
  logic    popped_valid;
  idx_t    head_index;
  cnt_t    entry_count;
  logic    list_empty;

  modport source (output valid, status, popped_index, popped_valid, head_index,
                  entry_count, list_empty, input ready);
  modport sink   (input valid, status, popped_index, popped_valid, head_index,
                  entry_count, list_empty, output ready);
endinterface

/* sv/task_linked_list_manager.sv */
// Circular doubly linked list over a fixed task pool, one opcode per beat.
// Depends on tll_pkg, tll_in_if and tll_out_if.
//
//   channel   direction  carries
//   in_ch     sink       opcode, task_index, anchor_index, anchor_valid
//   out_ch    source     status, popped_index/valid, head_index, entry_count, list_empty
//
// A beat's result is loaded into the result register when the request register
// advances: the update runs combinationally from the request register into it.
// One beat per cycle unless stalled; the next/prev tables are flop arrays with
// one read address and two write ports each. Reset clears the linked bits, head
// and count; link entries are written before any read of a linked task.
// A stalled result holds, the request register then holds, and the input stalls.
module task_linked_list_manager
  import tll_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tll_in_if.sink     in_ch,
  tll_out_if.source  out_ch
);

  // Request register
  logic    s1_valid_r;
  opcode_t s1_op_r;
  idx_t    s1_task_r;
  idx_t    s1_anchor_r;
  logic    s1_anchor_vld_r;

  // List state
  idx_t                  next_r [TASK_SLOTS];
  idx_t                  prev_r [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] flag_r;
  logic [TASK_SLOTS-1:0] flag_nxt;
  idx_t                  front_r;
  idx_t                  front_nxt;
  cnt_t                  count_r;
  cnt_t                  count_nxt;

  // Result register
  logic    out_valid_r;
  status_t status_r;
  status_t status_nxt;
  idx_t    popped_r;
  idx_t    popped_nxt;
  logic    popped_vld_r;
  logic    popped_vld_nxt;
  idx_t    head_r;
  cnt_t    count_out_r;
  logic    empty_out_r;

  logic advance;
  logic list_empty;
  logic push_path;
  logic empty_push;
  idx_t rem_tgt;     // task being unlinked (head on pop)
  idx_t link_anc;    // task the new one goes ahead of
  idx_t prv_addr;
  idx_t prv_rd;
  idx_t nxt_rd;

  // Table write ports
  logic n_we0, n_we1, p_we0, p_we1;
  idx_t n_wa0, n_wa1, p_wa0, p_wa1;
  idx_t n_wd0, n_wd1, p_wd0, p_wd1;

  // Move the request register forward when the result register can take it.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r         <= in_ch.opcode;
      s1_task_r       <= in_ch.task_index;
      s1_anchor_r     <= in_ch.anchor_index;
      s1_anchor_vld_r <= in_ch.anchor_valid;
    end
  end

  // Address selection: insert on an empty list or without an anchor is a push
  // at the tail, which is "ahead of the head" in a circular list.
  assign list_empty = (count_r == '0);
  assign push_path  = (s1_op_r == OP_PUSH_BACK) ||
                      ((s1_op_r == OP_INSERT_BEFORE) && (list_empty || !s1_anchor_vld_r));
  assign empty_push = push_path && list_empty;
  assign rem_tgt    = (s1_op_r == OP_POP_FRONT) ? front_r : s1_task_r;
  assign link_anc   = push_path ? front_r : s1_anchor_r;
  assign prv_addr   = ((s1_op_r == OP_POP_FRONT) || (s1_op_r == OP_REMOVE)) ?
                      rem_tgt : link_anc;
  assign prv_rd     = prev_r[prv_addr];
  assign nxt_rd     = next_r[rem_tgt];

  always_comb begin
    status_nxt     = ST_OK;
    popped_nxt     = '0;
    popped_vld_nxt = 1'b0;
    flag_nxt       = flag_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    n_we0 = 1'b0; n_wa0 = '0; n_wd0 = '0;
    n_we1 = 1'b0; n_wa1 = '0; n_wd1 = '0;
    p_we0 = 1'b0; p_wa0 = '0; p_wd0 = '0;
    p_we1 = 1'b0; p_wa1 = '0; p_wd1 = '0;

    case (s1_op_r)
      OP_PUSH_BACK, OP_INSERT_BEFORE: begin
        if (flag_r[s1_task_r]) begin
          status_nxt = ST_ALREADY;
        end else if (!push_path && !flag_r[s1_anchor_r]) begin
          status_nxt = ST_NOT_LINKED;
        end else begin
          // Link the task between the anchor's predecessor and the anchor;
          // a lone task points at itself both ways.
          n_we0 = 1'b1; n_wa0 = s1_task_r; n_wd0 = empty_push ? s1_task_r : link_anc;
          p_we0 = 1'b1; p_wa0 = s1_task_r; p_wd0 = empty_push ? s1_task_r : prv_rd;
          n_we1 = !empty_push; n_wa1 = prv_rd;   n_wd1 = s1_task_r;
          p_we1 = !empty_push; p_wa1 = link_anc; p_wd1 = s1_task_r;
          flag_nxt[s1_task_r] = 1'b1;
          count_nxt = count_r + cnt_t'(1);
          if (empty_push || (!push_path && (front_r == s1_anchor_r))) begin
            front_nxt = s1_task_r;
          end
        end
      end
      OP_POP_FRONT, OP_REMOVE: begin
        if (list_empty && (s1_op_r == OP_POP_FRONT)) begin
          status_nxt = ST_EMPTY;
        end else if (list_empty || !flag_r[rem_tgt]) begin
          status_nxt = ST_NOT_LINKED;
        end else begin
          if (s1_op_r == OP_POP_FRONT) begin
            popped_nxt     = front_r;
            popped_vld_nxt = 1'b1;
          end
          flag_nxt[rem_tgt] = 1'b0;
          if (count_r <= cnt_t'(1)) begin
            front_nxt = '0;
            count_nxt = '0;
          end else begin
            // Splice the neighbors together.
            n_we0 = 1'b1; n_wa0 = prv_rd; n_wd0 = nxt_rd;
            p_we0 = 1'b1; p_wa0 = nxt_rd; p_wd0 = prv_rd;
            if (front_r == rem_tgt) begin
              front_nxt = nxt_rd;
            end
            count_nxt = count_r - cnt_t'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Link tables: no reset, entries are written before a linked read.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (n_we0) next_r[n_wa0] <= n_wd0;
      if (n_we1) next_r[n_wa1] <= n_wd1;
      if (p_we0) prev_r[p_wa0] <= p_wd0;
      if (p_we1) prev_r[p_wa1] <= p_wd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= '0;
      front_r <= '0;
      count_r <= '0;
    end else if (advance) begin
      flag_r  <= flag_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r     <= status_nxt;
      popped_r     <= popped_nxt;
      popped_vld_r <= popped_vld_nxt;
      head_r       <= (count_nxt == '0) ? '0 : front_nxt;
      count_out_r  <= count_nxt;
      empty_out_r  <= (count_nxt == '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.popped_index = popped_r;
  assign out_ch.popped_valid = popped_vld_r;
  assign out_ch.head_index   = head_r;
  assign out_ch.entry_count  = count_out_r;
  assign out_ch.list_empty   = empty_out_r;

  // The count always matches the number of linked tasks.
  a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(flag_r) == int'(count_r))
    else $error("member count differs from linked task count");

  // A non-empty list always has a linked head.
  a_head_linked: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> flag_r[front_r])
    else $error("head task is not linked");

  // An empty list keeps its head at zero.
  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == '0))
    else $error("empty list with nonzero head");

  // A successful pop leaves the popped task unlinked.
  a_pop_unlinks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && popped_vld_nxt) |=> !flag_r[$past(front_r)])
    else $error("popped task still linked");

endmodule

/* sim/tb_task_linked_list_manager.sv */
// Self-checking testbench for task_linked_list_manager: a local list predictor, random
// beat traffic with sender bursts, receiver stalls and a long output hold-off.
// Depends on tll_pkg, tll_in_if, tll_out_if and the task_linked_list_manager RTL.
module tb_task_linked_list_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import tll_pkg::*;

  // One expected result beat, field for field as the output channel carries it.
  typedef struct packed {
    status_t status;
    idx_t    popped_index;
    logic    popped_valid;
    idx_t    head_index;
    cnt_t    entry_count;
    logic    list_empty;
  } list_view_t;

  logic clk;
  logic rst_n;

  tll_in_if  in_if();
  tll_out_if out_if();

  task_linked_list_manager i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predicted list state: links, membership bits, head and size.
  idx_t list_next [TASK_SLOTS];
  idx_t list_prev [TASK_SLOTS];
  logic task_linked [TASK_SLOTS];
  idx_t list_head;
  cnt_t list_size;

  list_view_t expected_results[$];
  int         error_count;

  // Sender burst bookkeeping and receiver hold-off request.
  int burst_left;
  int hold_cycles;
  int rx_mode;
  int rx_tick;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------

  // Splice unlinked task t in ahead of linked task a.
  function automatic void link_ahead(idx_t t, idx_t a);
    idx_t p;
    p            = list_prev[a];
    list_next[t] = a;
    list_prev[t] = p;
    list_next[p] = t;
    list_prev[a] = t;
    task_linked[t] = 1'b1;
    list_size++;
  endfunction

  // Append at the tail, which is the slot just ahead of the head.
  function automatic status_t append_task(idx_t t);
    if (task_linked[t]) return ST_ALREADY;
    if (list_size == 0) begin
      list_head      = t;
      list_next[t]   = t;
      list_prev[t]   = t;
      task_linked[t] = 1'b1;
      list_size      = cnt_t'(1);
    end else begin
      link_ahead(t, list_head);
    end
    return ST_OK;
  endfunction

  // Unlink a linked task; the last one leaves the head parked at zero.
  function automatic void unlink_task(idx_t t);
    idx_t n;
    idx_t p;
    if (list_size <= 1) begin
      list_head = '0;
      list_size = '0;
    end else begin
      n            = list_next[t];
      p            = list_prev[t];
      list_next[p] = n;
      list_prev[n] = p;
      if (list_head == t) list_head = n;
      list_size--;
    end
    task_linked[t] = 1'b0;
  endfunction

  // Apply one request beat to the predicted list and return the result beat.
  function automatic list_view_t apply_list_op(opcode_t op, idx_t t, idx_t a, logic av);
    list_view_t r;
    r              = '0;
    r.status       = ST_OK;
    r.popped_index = '0;
    r.popped_valid = 1'b0;
    case (op)
      OP_PUSH_BACK: begin
        r.status = append_task(t);
      end
      OP_INSERT_BEFORE: begin
        // Empty list or no anchor given: fall back to an append.
        if (list_size == 0 || !av) begin
          r.status = append_task(t);
        end else if (task_linked[t]) begin
          r.status = ST_ALREADY;
        end else if (!task_linked[a]) begin
          r.status = ST_NOT_LINKED;
        end else begin
          link_ahead(t, a);
          if (list_head == a) list_head = t;
        end
      end
      OP_POP_FRONT: begin
        if (list_size == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_index = list_head;
          r.popped_valid = 1'b1;
          unlink_task(list_head);
        end
      end
      default: begin
        if (list_size == 0 || !task_linked[t]) r.status = ST_NOT_LINKED;
        else unlink_task(t);
      end
    endcase
    r.head_index  = (list_size == 0) ? idx_t'(0) : list_head;
    r.entry_count = list_size;
    r.list_empty  = (list_size == 0);
    return r;
  endfunction

  // Pick a task whose membership matches want_linked; any task if none does.
  function automatic idx_t pick_task(bit want_linked);
    int   start;
    idx_t c;
    start = $urandom_range(0, TASK_SLOTS - 1);
    for (int k = 0; k < TASK_SLOTS; k++) begin
      c = idx_t'((start + k) % TASK_SLOTS);
      if (task_linked[c] == want_linked) return c;
    end
    return idx_t'(start);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one request beat per call, bursts with random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_op(opcode_t op, idx_t t, idx_t a, logic av);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.task_index   <= t;
    in_if.anchor_index <= a;
    in_if.anchor_valid <= av;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(apply_list_op(op, t, a, av));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      // Drop valid only when a real gap follows, so it is never lowered and
      // raised within one step.
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: rotate through stall patterns, honor a requested hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= (rx_tick % 3) != 0;
          2: out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= $urandom_range(0, 7) != 0;
        endcase
        rx_tick++;
        if (rx_tick % 64 == 0) rx_mode = (rx_mode + 1) % 4;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every taken result beat with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    list_view_t exp_beat;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no request pending: status %0d head %0d count %0d",
               out_if.status, out_if.head_index, out_if.entry_count);
        error_count++;
      end else begin
        exp_beat = expected_results.pop_front();
        if (out_if.status !== exp_beat.status) begin
          $error("status: expected %0d, got %0d", exp_beat.status, out_if.status);
          error_count++;
        end
        if (out_if.popped_index !== exp_beat.popped_index) begin
          $error("popped_index: expected %0d, got %0d",
                 exp_beat.popped_index, out_if.popped_index);
          error_count++;
        end
        if (out_if.popped_valid !== exp_beat.popped_valid) begin
          $error("popped_valid: expected %0d, got %0d",
                 exp_beat.popped_valid, out_if.popped_valid);
          error_count++;
        end
        if (out_if.head_index !== exp_beat.head_index) begin
          $error("head_index: expected %0d, got %0d",
                 exp_beat.head_index, out_if.head_index);
          error_count++;
        end
        if (out_if.entry_count !== exp_beat.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 exp_beat.entry_count, out_if.entry_count);
          error_count++;
        end
        if (out_if.list_empty !== exp_beat.list_empty) begin
          $error("list_empty: expected %0d, got %0d",
                 exp_beat.list_empty, out_if.list_empty);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pop and remove on an empty list; insert_before on an empty list appends.
  task automatic test_empty_list();
    send_op(OP_POP_FRONT, 5'd0, 5'd0, 1'b0);
    send_op(OP_REMOVE, 5'd5, 5'd0, 1'b0);
    send_op(OP_INSERT_BEFORE, 5'd0, 5'd31, 1'b1);   // list: 0
  endtask

  // Append, then retry a linked task by both insert opcodes.
  task automatic test_duplicate_links();
    send_op(OP_PUSH_BACK, 5'd31, 5'd0, 1'b0);       // list: 0 31
    send_op(OP_PUSH_BACK, 5'd0, 5'd31, 1'b1);       // already linked
    send_op(OP_INSERT_BEFORE, 5'd31, 5'd0, 1'b1);   // already linked
  endtask

  // Insert ahead of the head, in the middle, before a missing anchor, and
  // with no anchor given.
  task automatic test_insert_before();
    send_op(OP_INSERT_BEFORE, 5'd10, 5'd0, 1'b1);   // list: 10 0 31
    send_op(OP_INSERT_BEFORE, 5'd20, 5'd31, 1'b1);  // list: 10 0 20 31
    send_op(OP_INSERT_BEFORE, 5'd21, 5'd7, 1'b1);   // anchor not linked
    send_op(OP_INSERT_BEFORE, 5'd7, 5'd0, 1'b0);    // list: 10 0 20 31 7
  endtask

  // Remove the head, a middle task, the tail, and a task no longer linked.
  task automatic test_remove();
    send_op(OP_REMOVE, 5'd10, 5'd0, 1'b0);
    send_op(OP_REMOVE, 5'd20, 5'd0, 1'b0);
    send_op(OP_REMOVE, 5'd7, 5'd0, 1'b0);           // list: 0 31
    send_op(OP_REMOVE, 5'd20, 5'd0, 1'b0);
  endtask

  // Pop down to empty, pop once more, then remove a lone task.
  task automatic test_pop_front();
    send_op(OP_POP_FRONT, 5'd0, 5'd0, 1'b0);
    send_op(OP_POP_FRONT, 5'd0, 5'd0, 1'b0);
    send_op(OP_POP_FRONT, 5'd0, 5'd0, 1'b0);
    send_op(OP_PUSH_BACK, 5'd5, 5'd0, 1'b0);
    send_op(OP_REMOVE, 5'd5, 5'd0, 1'b0);
  endtask

  // Fill the whole pool in random order, bounce off a full list, then drain.
  task automatic test_fill_and_drain();
    idx_t t;
    for (int k = 0; k < TASK_SLOTS; k++) begin
      t = pick_task(1'b0);
      if ($urandom_range(0, 1)) send_op(OP_PUSH_BACK, t, idx_t'($urandom), 1'b0);
      else send_op(OP_INSERT_BEFORE, t, pick_task(1'b1), 1'b1);
    end
    send_op(OP_INSERT_BEFORE, pick_task(1'b1), pick_task(1'b1), 1'b1);
    send_op(OP_PUSH_BACK, pick_task(1'b1), 5'd0, 1'b0);
    while (list_size != 0) begin
      if ($urandom_range(0, 1)) send_op(OP_POP_FRONT, idx_t'($urandom), idx_t'($urandom), 1'b0);
      else send_op(OP_REMOVE, pick_task(1'b1), idx_t'($urandom), 1'b0);
    end
  endtask

  // Mostly well-formed traffic steered by the predicted size, some noise.
  task automatic run_random_traffic(int n_items);
    int add_pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_op(opcode_t'($urandom_range(0, 3)), idx_t'($urandom), idx_t'($urandom),
                1'($urandom_range(0, 1)));
      end else begin
        add_pct = (list_size < 8) ? 65 : ((list_size > 24) ? 30 : 50);
        if ($urandom_range(0, 99) < add_pct) begin
          if ($urandom_range(0, 1))
            send_op(OP_PUSH_BACK, pick_task(1'b0), idx_t'($urandom),
                    1'($urandom_range(0, 1)));
          else
            send_op(OP_INSERT_BEFORE, pick_task(1'b0), pick_task(1'b1),
                    $urandom_range(0, 9) != 0);
        end else if ($urandom_range(0, 1)) begin
          send_op(OP_POP_FRONT, idx_t'($urandom), idx_t'($urandom),
                  1'($urandom_range(0, 1)));
        end else begin
          send_op(OP_REMOVE, pick_task(1'b1), idx_t'($urandom),
                  1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_traffic(660);
  endtask

  // Hold the output off for a long stretch while requests keep coming, so
  // the pipeline fills and pushes back on the input.
  task automatic test_output_backpressure();
    hold_cycles = 300;
    run_random_traffic(60);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < TASK_SLOTS; k++) begin
      list_next[k]   = '0;
      list_prev[k]   = '0;
      task_linked[k] = 1'b0;
    end
    list_head   = '0;
    list_size   = '0;
    error_count = 0;
    burst_left  = 0;
    hold_cycles = 0;
    rx_mode     = 0;
    rx_tick     = 0;

    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= OP_PUSH_BACK;
    in_if.task_index   <= '0;
    in_if.anchor_index <= '0;
    in_if.anchor_valid <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_duplicate_links();
    test_insert_before();
    test_remove();
    test_pop_front();
    test_fill_and_drain();
    test_random_traffic();
    test_output_backpressure();

    in_if.valid <= 1'b0;
    // Drain: wait for every expected beat, then wait on for strays.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tll_pkg.sv
sv/tll_in_if.sv
sv/tll_out_if.sv
sv/task_linked_list_manager.sv
sim/tb_task_linked_list_manager.sv
